FILE: sv/fhfd_pkg.sv
// ----------------------------------------------------------------------------
// fhfd_pkg
// Shared types and constants of the hole-fill dilation block.
// ----------------------------------------------------------------------------
package fhfd_pkg;

  localparam int CHAN_W  = 16;
  localparam int FRAC_W  = 8;
  localparam int NCH     = 4;
  localparam int FW_W    = 12;
  localparam int FH_W    = 13;
  localparam int IDX_W   = 2;
  localparam int CDATA_W = 13;

  localparam int SUM_W   = CHAN_W + 2;
  localparam int NUM_W   = SUM_W + FRAC_W + 1;
  localparam int DEN_W   = SUM_W;
  localparam int QB      = CHAN_W + 1;
  localparam int QBI_W   = $clog2(QB);

  localparam logic [QB-1:0]     CH_MAX_Q = QB'((1 << (CHAN_W - 1)) - 1);
  localparam logic [CHAN_W-1:0] CH_MAX   = CHAN_W'((1 << (CHAN_W - 1)) - 1);
  localparam logic [CHAN_W-1:0] CH_MIN   = CHAN_W'(1 << (CHAN_W - 1));
  localparam logic [CHAN_W-1:0] W_ONE    = CHAN_W'(1 << FRAC_W);

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef logic [NCH-1:0][CHAN_W-1:0] pixel_t;

endpackage

FILE: sv/fhfd_if.sv
// ----------------------------------------------------------------------------
// fhfd interfaces
// Pixel input, result output and register write channels.
// ----------------------------------------------------------------------------
interface fhfd_pix_if;
  import fhfd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic signed [CHAN_W-1:0] in_x;
  logic signed [CHAN_W-1:0] in_y;
  logic signed [CHAN_W-1:0] in_z;
  logic signed [CHAN_W-1:0] in_w;
  modport source (output valid, operation, in_x, in_y, in_z, in_w, input ready);
  modport sink (input valid, operation, in_x, in_y, in_z, in_w, output ready);
endinterface

interface fhfd_res_if;
  import fhfd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CHAN_W-1:0] out_x;
  logic signed [CHAN_W-1:0] out_y;
  logic signed [CHAN_W-1:0] out_z;
  logic signed [CHAN_W-1:0] out_w;
  logic                     was_filled;
  logic                     frame_last;
  modport source (output valid, out_x, out_y, out_z, out_w, was_filled, frame_last,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, was_filled, frame_last,
                output ready);
endinterface

interface fhfd_cfg_if;
  import fhfd_pkg::*;
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   index;
  logic [CDATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/fhfd_ram.sv
// ----------------------------------------------------------------------------
// fhfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fhfd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/four_neighbour_hole_fill_dilation.sv
// ----------------------------------------------------------------------------
// four_neighbour_hole_fill_dilation
// Fills empty pixels of a streamed four-channel image with the weighted
// average of their four original neighbours.
// ----------------------------------------------------------------------------
// One transaction is taken every clock cycle, pixel or flush alike, and a
// stall on the result side holds the whole pipeline. A pixel's result
// leaves frame_width + 1 pixel transactions after it entered; the tail of a
// frame is drained by flush transactions. A result passes through 21
// register stages: the history read, the neighbour sum, the divider
// set-up, one quotient bit per stage of a 17-stage restoring divider,
// and the output register. The pixel history
// lives in five copies of one circular RAM of
// 2**clog2(2*MAX_WIDTH+4) entries, one read port for the pixel and each
// neighbour; it needs no clearing after reset.
// ----------------------------------------------------------------------------
module four_neighbour_hole_fill_dilation #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fhfd_pix_if.sink    pix_i,
  fhfd_res_if.source  res_o,
  fhfd_cfg_if.sink    cfg_i
);
  import fhfd_pkg::*;

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int PW    = $clog2(MAX_WIDTH + 2);
  localparam int AW    = $clog2(2 * MAX_WIDTH + 4);
  localparam int DEPTH = 2 ** AW;
  localparam int NRD   = 5;

  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
    logic last;
  } nb_t;

  typedef struct packed {
    logic fill;
    logic last;
    pixel_t centre;
  } side_t;

  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] rem;
    logic [QB-1:0]    quo;
  } div_t;

  typedef struct packed {
    pixel_t pix;
    logic   fill;
    logic   last;
  } res_t;

  function automatic div_t div_step(div_t d, logic [DEN_W-1:0] den, logic [QBI_W-1:0] b);
    div_t           r;
    logic [DEN_W:0] t;
    r = d;
    t = {d.rem, d.num[b]};
    if (t >= {1'b0, den}) begin
      r.quo[b] = 1'b1;
      r.rem    = DEN_W'(t - {1'b0, den});
    end else begin
      r.rem = DEN_W'(t);
    end
    return r;
  endfunction

  // registers and counters
  logic [FW_W-1:0] frame_width_q;
  logic [FH_W-1:0] frame_height_q;
  logic [WW-1:0]   out_col_q;
  logic [FH_W-1:0] out_row_q;
  logic [PW-1:0]   pending_q;
  logic [AW-1:0]   wp_q;

  logic [WW-1:0]   w_eff;
  logic [FH_W-1:0] h_eff;
  logic [WW:0]     col_nx;
  logic [FH_W:0]   row_nx;
  logic            col_end;
  logic            row_end;
  logic            pend_full;
  logic            is_flush;
  logic            flush_ok;
  logic            emit;
  logic            en;
  logic            accept;

  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_q);
    end
    h_eff = (frame_height_q == '0) ? FH_W'(1) : frame_height_q;
  end

  assign col_nx    = {1'b0, out_col_q} + (WW + 1)'(1);
  assign row_nx    = {1'b0, out_row_q} + (FH_W + 1)'(1);
  assign col_end   = col_nx == {1'b0, w_eff};
  assign row_end   = row_nx == {1'b0, h_eff};
  assign pend_full = pending_q >= (PW'(w_eff) + PW'(1));
  assign is_flush  = pix_i.operation == OP_FLUSH;
  assign flush_ok  = (pending_q != '0) &&
                     (!row_end ? pend_full : (!col_end ? (pending_q >= PW'(2)) : 1'b1));
  assign emit      = is_flush ? flush_ok : pend_full;

  logic   res_valid_q;
  res_t   res_q;

  assign en          = !res_valid_q || res_o.ready;
  assign accept      = pix_i.valid && en;
  assign pix_i.ready = en;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FW_W'(256);
      frame_height_q <= FH_W'(256);
      out_col_q      <= '0;
      out_row_q      <= '0;
      pending_q      <= '0;
      wp_q           <= '0;
    end else if (cfg_i.valid &&
                 (cfg_i.index == REG_FRAME_WIDTH || cfg_i.index == REG_FRAME_HEIGHT)) begin
      if (cfg_i.index == REG_FRAME_WIDTH) begin
        frame_width_q <= FW_W'(cfg_i.data);
      end else begin
        frame_height_q <= cfg_i.data;
      end
      out_col_q <= '0;
      out_row_q <= '0;
      pending_q <= '0;
    end else if (accept) begin
      if (!is_flush) begin
        wp_q <= wp_q + AW'(1);
        if (!emit) begin
          pending_q <= pending_q + PW'(1);
        end
      end else if (emit) begin
        pending_q <= pending_q - PW'(1);
      end
      if (emit) begin
        if (col_end) begin
          out_col_q <= '0;
          out_row_q <= row_end ? '0 : FH_W'(row_nx);
        end else begin
          out_col_q <= WW'(col_nx);
        end
      end
    end
  end

  // history reads: centre, up, down, left, right
  logic [AW-1:0] centre_a;
  logic [AW-1:0] raddr [NRD];
  pixel_t        rd    [NRD];
  pixel_t        wdata;

  assign centre_a = wp_q - AW'(pending_q);
  assign raddr[0] = centre_a;
  assign raddr[1] = centre_a - AW'(w_eff);
  assign raddr[2] = centre_a + AW'(w_eff);
  assign raddr[3] = centre_a - AW'(1);
  assign raddr[4] = centre_a + AW'(1);
  assign wdata    = {pix_i.in_w, pix_i.in_z, pix_i.in_y, pix_i.in_x};

  for (genvar r = 0; r < NRD; r++) begin : g_hist
    fhfd_ram #(
      .WIDTH (NCH * CHAN_W),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (accept && !is_flush),
      .waddr_i (wp_q),
      .wdata_i (wdata),
      .re_i    (en),
      .raddr_i (raddr[r]),
      .rdata_o (rd[r])
    );
  end

  // stage 1: neighbour sums
  logic v1_q;
  nb_t  nb1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= accept && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nb1_q <= '{up: out_row_q != '0, down: !row_end, left: out_col_q != '0,
                 right: !col_end, last: row_end && col_end};
    end
  end

  logic signed [SUM_W-1:0] sum1 [NCH];
  logic                    fill1;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      sum1[c] = (nb1_q.up    ? SUM_W'($signed(rd[1][c])) : '0) +
                (nb1_q.down  ? SUM_W'($signed(rd[2][c])) : '0) +
                (nb1_q.left  ? SUM_W'($signed(rd[3][c])) : '0) +
                (nb1_q.right ? SUM_W'($signed(rd[4][c])) : '0);
    end
    fill1 = (rd[0][NCH-1] == '0) && (sum1[NCH-1] > 0);
  end

  // stage 2: divider set-up
  logic                    v2_q;
  side_t                   sd2_q;
  logic signed [SUM_W-1:0] sum2_q [NCH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd2_q  <= '{fill: fill1, last: nb1_q.last, centre: rd[0]};
      sum2_q <= sum1;
    end
  end

  logic [DEN_W-1:0] den2;
  div_t             prep [3];

  always_comb begin
    logic [SUM_W-1:0] mag;
    den2 = {sum2_q[NCH-1][SUM_W-2:0], 1'b0};
    for (int c = 0; c < 3; c++) begin
      mag          = sum2_q[c][SUM_W-1] ? SUM_W'(-sum2_q[c]) : SUM_W'(sum2_q[c]);
      prep[c].neg  = sum2_q[c][SUM_W-1];
      prep[c].num  = (NUM_W'(mag) << (FRAC_W + 1)) + NUM_W'(sum2_q[NCH-1][SUM_W-2:0]);
      prep[c].rem  = DEN_W'(prep[c].num >> QB);
      prep[c].ovf  = prep[c].rem >= den2;
      prep[c].quo  = '0;
    end
  end

  // divider pipeline, one quotient bit per stage
  logic             dv_q   [QB+1];
  side_t            dsd_q  [QB+1];
  logic [DEN_W-1:0] dden_q [QB+1];
  div_t             dch_q  [QB+1][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dsd_q[0]  <= sd2_q;
      dden_q[0] <= den2;
      dch_q[0]  <= prep;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[s+1] <= 1'b0;
      end else if (en) begin
        dv_q[s+1] <= dv_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dsd_q[s+1]  <= dsd_q[s];
        dden_q[s+1] <= dden_q[s];
        for (int c = 0; c < 3; c++) begin
          dch_q[s+1][c] <= div_step(dch_q[s][c], dden_q[s], QBI_W'(QB - 1 - s));
        end
      end
    end
  end

  // saturation and output register
  res_t res_d;

  always_comb begin
    pixel_t q;
    q = dsd_q[QB].centre;
    for (int c = 0; c < 3; c++) begin
      if (!dch_q[QB][c].neg) begin
        q[c] = (dch_q[QB][c].ovf || dch_q[QB][c].quo > CH_MAX_Q) ? CH_MAX :
               CHAN_W'(dch_q[QB][c].quo);
      end else begin
        q[c] = (dch_q[QB][c].ovf || dch_q[QB][c].quo > CH_MAX_Q + QB'(1)) ? CH_MIN :
               CHAN_W'(QB'(~dch_q[QB][c].quo + QB'(1)));
      end
    end
    q[NCH-1] = W_ONE;
    res_d.pix  = dsd_q[QB].fill ? q : dsd_q[QB].centre;
    res_d.fill = dsd_q[QB].fill;
    res_d.last = dsd_q[QB].last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (en) begin
      res_valid_q <= dv_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.out_x      = res_q.pix[0];
  assign res_o.out_y      = res_q.pix[1];
  assign res_o.out_z      = res_q.pix[2];
  assign res_o.out_w      = res_q.pix[3];
  assign res_o.was_filled = res_q.fill;
  assign res_o.frame_last = res_q.last;

  // checks
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= PW'(w_eff) + PW'(1))
    else $error("pending count above frame width plus one");

  a_fill_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.fill |-> res_q.pix[NCH-1] == W_ONE)
    else $error("filled pixel without unit weight");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> res_valid_q && !res_o.ready)
    else $error("input stalled without a blocked result");

  a_idle_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_flush && pending_q == '0 && !cfg_i.valid |=> v1_q == 1'b0 || !$past(en))
    else $error("flush with nothing pending produced a result");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams frames of four-channel pixels and flush transactions into the
// hole-fill dilation block under random valid/ready gaps, predicts each
// filled or passed-through pixel from a local pixel history, and compares
// every result field with the oldest prediction. Frame sizes are changed
// between phases, the register extremes among them.
// ----------------------------------------------------------------------------
module tb;
  import fhfd_pkg::*;

  localparam int HIST_D = 8192;
  localparam int LAT    = 40;

  typedef struct {
    logic                     op;
    logic signed [CHAN_W-1:0] ch [NCH];
  } pix_item_t;

  typedef struct {
    logic signed [CHAN_W-1:0] ch [NCH];
    logic                     filled;
    logic                     last;
  } fill_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fhfd_pix_if pix ();
  fhfd_res_if res ();
  fhfd_cfg_if cfg ();

  four_neighbour_hole_fill_dilation u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  always #1 clk_i = ~clk_i;

  pix_item_t pixel_q [$];
  fill_res_t fill_q [$];
  int        fails = 0;
  int        cycle = 0;
  logic      pix_took = 1'b0;

  logic signed [CHAN_W-1:0] hist [HIST_D][NCH];
  int unsigned hist_ptr = 0;
  int unsigned reg_w = 256;
  int unsigned reg_h = 256;
  int unsigned out_row = 0;
  int unsigned out_col = 0;
  int unsigned pend = 0;

  function automatic int unsigned eff_w();
    if (reg_w == 0) return 1;
    if (reg_w > 2048) return 2048;
    return reg_w;
  endfunction

  function automatic int unsigned eff_h();
    return (reg_h == 0) ? 1 : reg_h;
  endfunction

  function automatic longint div_round_sat(longint n, longint d);
    longint mag;
    longint q;
    mag = (n < 0) ? -n : n;
    q = (2 * mag + d) / (2 * d);
    q = (n < 0) ? -q : q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  function automatic void fill_pixel(output fill_res_t r);
    int unsigned w;
    int unsigned h;
    int unsigned ds [4];
    int          n;
    longint      sum [NCH];
    int unsigned idx;
    w = eff_w();
    h = eff_h();
    n = 0;
    idx = (hist_ptr - pend) % HIST_D;
    for (int i = 0; i < NCH; i++) begin
      r.ch[i] = hist[idx][i];
      sum[i] = 0;
    end
    r.filled = 1'b0;
    r.last = (out_row + 1 == h) && (out_col + 1 == w);
    if (r.ch[3] == 0) begin
      if (out_row >= 1) begin ds[n] = pend + w; n++; end
      if (out_row + 1 < h) begin ds[n] = pend - w; n++; end
      if (out_col >= 1) begin ds[n] = pend + 1; n++; end
      if (out_col + 1 < w) begin ds[n] = pend - 1; n++; end
      for (int k = 0; k < n; k++) begin
        idx = (hist_ptr - ds[k]) % HIST_D;
        for (int i = 0; i < NCH; i++) sum[i] += hist[idx][i];
      end
      if (sum[3] > 0) begin
        for (int i = 0; i < 3; i++) r.ch[i] = CHAN_W'(div_round_sat(sum[i] * 256, sum[3]));
        r.ch[3] = W_ONE;
        r.filled = 1'b1;
      end
    end
    pend--;
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) out_row = 0;
    end
  endfunction

  function automatic void predict(pix_item_t it);
    fill_res_t r;
    int unsigned w;
    int unsigned h;
    w = eff_w();
    h = eff_h();
    if (it.op == OP_PIXEL) begin
      for (int i = 0; i < NCH; i++) hist[hist_ptr % HIST_D][i] = it.ch[i];
      hist_ptr++;
      pend++;
      if (pend > w + 1) begin
        fill_pixel(r);
        fill_q.insert(fill_q.size(), r);
      end
      return;
    end
    if (pend == 0) return;
    if (out_row + 1 < h) begin
      if (pend < w + 1) return;
    end else if (out_col + 1 < w) begin
      if (pend < 2) return;
    end
    fill_pixel(r);
    fill_q.insert(fill_q.size(), r);
  endfunction

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    pix_took <= pix.valid && pix.ready;
    if (pix.valid && pix.ready) begin
      pix_item_t it;
      it.op = pix.operation;
      it.ch[0] = pix.in_x;
      it.ch[1] = pix.in_y;
      it.ch[2] = pix.in_z;
      it.ch[3] = pix.in_w;
      predict(it);
    end
  end

  function automatic logic quiet();
    return (cycle >= 3000) && (cycle < 6000);
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni && (!pix.valid || pix_took)) begin
      if (pixel_q.size() != 0 && (quiet() || $urandom_range(99) >= 20)) begin
        pix_item_t it;
        it = pixel_q.pop_front();
        pix.valid <= 1'b1;
        pix.operation <= it.op;
        pix.in_x <= it.ch[0];
        pix.in_y <= it.ch[1];
        pix.in_z <= it.ch[2];
        pix.in_w <= it.ch[3];
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    res.ready <= quiet() || ($urandom_range(99) >= 20);
  end

  always @(posedge clk_i) begin
    if (res.valid && res.ready) begin
      if (fill_q.size() == 0) begin
        $error("result with no prediction pending");
        fails++;
      end else begin
        fill_res_t e;
        e = fill_q.pop_front();
        if (res.out_x !== e.ch[0]) begin
          $error("out_x exp %0d got %0d", e.ch[0], res.out_x); fails++;
        end
        if (res.out_y !== e.ch[1]) begin
          $error("out_y exp %0d got %0d", e.ch[1], res.out_y); fails++;
        end
        if (res.out_z !== e.ch[2]) begin
          $error("out_z exp %0d got %0d", e.ch[2], res.out_z); fails++;
        end
        if (res.out_w !== e.ch[3]) begin
          $error("out_w exp %0d got %0d", e.ch[3], res.out_w); fails++;
        end
        if (res.was_filled !== e.filled) begin
          $error("was_filled exp %0b got %0b", e.filled, res.was_filled); fails++;
        end
        if (res.frame_last !== e.last) begin
          $error("frame_last exp %0b got %0b", e.last, res.frame_last); fails++;
        end
      end
    end
  end

  function automatic void add_px(logic signed [CHAN_W-1:0] x, logic signed [CHAN_W-1:0] y,
                                 logic signed [CHAN_W-1:0] z, logic signed [CHAN_W-1:0] w);
    pix_item_t it;
    it.op = OP_PIXEL;
    it.ch[0] = x;
    it.ch[1] = y;
    it.ch[2] = z;
    it.ch[3] = w;
    pixel_q.insert(pixel_q.size(), it);
  endfunction

  function automatic void add_flush();
    pix_item_t it;
    it.op = OP_FLUSH;
    for (int i = 0; i < NCH; i++) it.ch[i] = CHAN_W'($urandom);
    pixel_q.insert(pixel_q.size(), it);
  endfunction

  function automatic void add_random_px();
    logic signed [CHAN_W-1:0] v [NCH];
    int unsigned sel;
    sel = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      if (sel < 60) v[i] = CHAN_W'($urandom);
      else v[i] = CHAN_W'($signed($urandom_range(1024)) - 512);
    end
    sel = $urandom_range(99);
    if (sel < 40) v[3] = '0;
    else if (sel < 75) v[3] = CHAN_W'($urandom_range(512, 1));
    else v[3] = CHAN_W'($urandom);
    add_px(v[0], v[1], v[2], v[3]);
  endfunction

  task automatic settle();
    do @(posedge clk_i);
    while (pixel_q.size() != 0 || pix.valid || fill_q.size() != 0);
    repeat (LAT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, int unsigned val);
    @(negedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= CDATA_W'(val);
    do @(posedge clk_i);
    while (!cfg.ready);
    if (idx == REG_FRAME_WIDTH) reg_w = val & 12'hFFF;
    else reg_h = val & 13'h1FFF;
    out_row = 0;
    out_col = 0;
    pend = 0;
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_frame(int unsigned w, int unsigned h);
    settle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  task automatic drain_frame();
    repeat (eff_w() + 2) add_flush();
  endtask

  initial begin
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    pix.valid = 1'b0;
    pix.operation = OP_PIXEL;
    pix.in_x = '0;
    pix.in_y = '0;
    pix.in_z = '0;
    pix.in_w = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_frame(3, 2);
    add_flush();
    add_px(100, -200, 300, 256);
    add_px(0, 0, 0, 0);
    add_px(32767, 32767, -32768, 1);
    add_flush();
    add_px(-32768, -32768, 32767, 1);
    add_px(-1, 1, 0, 0);
    add_px(5, 6, 7, -256);
    repeat (6) add_px(1, 2, 3, 0);
    add_px(-32768, 32767, -1, -32768);
    add_px(32767, -32768, 0, 32767);
    add_px(0, 0, 0, 0);
    add_flush();
    add_px(-1, -1, -1, -1);
    add_px(0, -1, 255, 0);
    drain_frame();

    set_frame(0, 0);
    repeat (20) add_random_px();
    drain_frame();
    set_frame(4095, 1);
    repeat (40) add_random_px();
    repeat (42) add_flush();
    set_frame(4, 8191);
    repeat (60) add_random_px();
    settle();
    repeat (40) add_random_px();
    set_frame(1, 5);
    repeat (15) add_random_px();
    drain_frame();

    sent = 0;
    while (sent < 750) begin
      if ($urandom_range(9) == 0) w = $urandom_range(40, 9);
      else w = $urandom_range(8, 1);
      h = $urandom_range(6, 1);
      set_frame(w, h);
      repeat ($urandom_range(3, 1) * w * h) begin
        if ($urandom_range(99) < 10) add_flush();
        add_random_px();
        sent++;
      end
      if ($urandom_range(3) != 0) drain_frame();
    end

    settle();
    if (fails == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
